[hdl/lsra_pkg.sv]
// shared widths, constants and result record for the linear scan register allocator
`default_nettype none

package lsra_pkg;

  // allocator sizing
  localparam int unsigned NumRegsDefault = 16;
  localparam int unsigned CfgW           = 5;
  localparam logic [CfgW-1:0] CfgReset   = 5'd16;

  // field widths
  localparam int unsigned VarW    = 16;
  localparam int unsigned PosW    = 16;
  localparam int unsigned RegNumW = 4;

  // stream payload widths (byte aligned)
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;

  // one allocation result
  typedef struct packed {
    logic [VarW-1:0]    spilled_variable;
    logic               spill_valid;
    logic [RegNumW-1:0] register_number;
    logic               got_register;
    logic [VarW-1:0]    result_variable;
  } lsra_result_t;

endpackage

`default_nettype wire

[hdl/linear_scan_register_allocator.sv]
// linear scan register allocator: one live interval in, one allocation result out
// an accepted interval passes the sweep, last and decide states; its result is then
// registered in the output register, and no new interval is taken before idle returns;
// the sweep over the entry memory reads one register entry per cycle through its single read port
// (a full output register with a stalled sink holds the decide state)
// reset: all registers free, registers_in_use = 16, no result pending
`default_nettype none

module linear_scan_register_allocator #(
  parameter int unsigned NUM_REGS = lsra_pkg::NumRegsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration: registers_in_use
  input  wire logic                          cfg_we_i,
  input  wire logic [lsra_pkg::CfgW-1:0]     cfg_wdata_i,
  // interval input
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // variable_id, interval_begin, interval_end
  input  wire logic [lsra_pkg::InDataW-1:0]  s_axis_tdata,
  // first_of_set
  input  wire logic                          s_axis_tuser,
  // allocation result
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // result_variable, got_register, register_number, spill_valid,
  // spilled_variable, zero pad
  output logic [lsra_pkg::OutDataW-1:0]      m_axis_tdata
);
  import lsra_pkg::*;

  localparam int unsigned IdxW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned CmpW = (IdxW > CfgW) ? IdxW : CfgW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_REGS - 1);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StSweep  = 4'b0010,
    StLast   = 4'b0100,
    StDecide = 4'b1000
  } lsra_state_e;

  lsra_state_e state_q, state_d;
  logic [CfgW-1:0]     cfg_q;
  logic [NUM_REGS-1:0] valid_q, valid_d;
  logic [IdxW-1:0]     cnt_q, cnt_d;

  // current interval
  logic [VarW-1:0] var_q;
  logic [PosW-1:0] beg_q, end_q;

  // sweep read stage
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;
  logic [PosW-1:0] rd_end_q;
  logic [VarW-1:0] rd_var_q;

  // sweep results
  logic            found_q, found_d;
  logic [IdxW-1:0] found_idx_q, found_idx_d;
  logic            cand_vld_q, cand_vld_d;
  logic [IdxW-1:0] cand_idx_q, cand_idx_d;
  logic [PosW-1:0] cand_end_q, cand_end_d;
  logic [VarW-1:0] cand_var_q, cand_var_d;

  // entry memories
  logic [PosW-1:0] mem_end [NUM_REGS];
  logic [VarW-1:0] mem_var [NUM_REGS];
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;

  // result handoff
  logic         res_valid, res_ready;
  lsra_result_t res;
  lsra_result_t out_res;

  logic in_xfer;
  logic live, expired, usable;

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign res_valid     = (state_q == StDecide);

  // per-entry checks on the word read last cycle
  assign expired = valid_q[rd_idx_q] && (rd_end_q < beg_q);
  assign live    = valid_q[rd_idx_q] && !expired;
  assign usable  = CmpW'(rd_idx_q) < CmpW'(cfg_q);

  // sweep and decision
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    cand_vld_d  = cand_vld_q;
    cand_idx_d  = cand_idx_q;
    cand_end_d  = cand_end_q;
    cand_var_d  = cand_var_q;
    mem_we      = 1'b0;
    mem_waddr   = found_idx_q;
    res         = '0;
    res.result_variable = var_q;

    // expire, track greatest end and lowest free usable register
    if (rd_vld_q) begin
      if (expired) begin
        valid_d[rd_idx_q] = 1'b0;
      end
      if (live && (!cand_vld_q || rd_end_q > cand_end_q)) begin
        cand_vld_d = 1'b1;
        cand_idx_d = rd_idx_q;
        cand_end_d = rd_end_q;
        cand_var_d = rd_var_q;
      end
      if (!live && usable && !found_q) begin
        found_d     = 1'b1;
        found_idx_d = rd_idx_q;
      end
    end

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (s_axis_tuser) begin
            valid_d = '0;
          end
          cnt_d      = '0;
          found_d    = 1'b0;
          cand_vld_d = 1'b0;
          state_d    = StSweep;
        end
      end
      StSweep: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = StLast;
        end
      end
      StLast: begin
        state_d = StDecide;
      end
      StDecide: begin
        if (found_q) begin
          res.got_register    = 1'b1;
          res.register_number = RegNumW'(found_idx_q);
        end else begin
          res.spill_valid = 1'b1;
          if (cand_vld_q && (cand_end_q > end_q)) begin
            res.got_register     = 1'b1;
            res.register_number  = RegNumW'(cand_idx_q);
            res.spilled_variable = cand_var_q;
          end else begin
            res.spilled_variable = var_q;
          end
        end
        if (res_ready) begin
          state_d = StIdle;
          if (found_q) begin
            valid_d[found_idx_q] = 1'b1;
            mem_we               = 1'b1;
          end else if (cand_vld_q && (cand_end_q > end_q)) begin
            mem_we    = 1'b1;
            mem_waddr = cand_idx_q;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cfg_q      <= CfgReset;
      valid_q    <= '0;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
      cand_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      cnt_q      <= cnt_d;
      rd_vld_q   <= (state_q == StSweep);
      found_q    <= found_d;
      cand_vld_q <= cand_vld_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      var_q <= s_axis_tdata[VarW-1:0];
      beg_q <= s_axis_tdata[VarW+PosW-1:VarW];
      end_q <= s_axis_tdata[VarW+2*PosW-1:VarW+PosW];
    end
    rd_idx_q    <= cnt_q;
    found_idx_q <= found_idx_d;
    cand_idx_q  <= cand_idx_d;
    cand_end_q  <= cand_end_d;
    cand_var_q  <= cand_var_d;
  end

  // entry memories: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_end[mem_waddr] <= end_q;
      mem_var[mem_waddr] <= var_q;
    end
    rd_end_q <= mem_end[cnt_q];
    rd_var_q <= mem_var[cnt_q];
  end

  // result register toward the sink
  lsra_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_ready_o (res_ready),
    .in_data_i  (res),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_res)
  );

  assign m_axis_tdata = {(OutDataW - $bits(lsra_result_t))'(0), out_res};

endmodule

`default_nettype wire

[hdl/lsra_out_reg.sv]
// output register that holds one allocation result until the sink takes it
`default_nettype none

module lsra_out_reg (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire lsra_pkg::lsra_result_t in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output lsra_pkg::lsra_result_t     out_data_o
);
  import lsra_pkg::*;

  logic         valid_q, valid_d;
  lsra_result_t data_q;

  // slot is free when empty or drained in this cycle
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

[hdl/lsra_checker.sv]
// port-level checks for the linear scan register allocator, bound to the top level
`default_nettype none

module lsra_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [lsra_pkg::OutDataW-1:0] m_axis_tdata
);
  import lsra_pkg::*;

  logic               got, spill;
  logic [RegNumW-1:0] reg_num;
  logic [VarW-1:0]    spilled;

  assign got     = m_axis_tdata[VarW];
  assign reg_num = m_axis_tdata[VarW+RegNumW:VarW+1];
  assign spill   = m_axis_tdata[VarW+RegNumW+1];
  assign spilled = m_axis_tdata[2*VarW+RegNumW+1:VarW+RegNumW+2];

  // one interval at a time: busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // an interval without a register must have been spilled, register number zero
  a_no_reg_means_spill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !got |-> spill && (reg_num == '0))
    else $error("interval neither allocated nor spilled");

  // no spill means a register was given and the spill field is zero
  a_no_spill_means_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !spill |-> got && (spilled == '0))
    else $error("inconsistent spill fields");

endmodule

bind linear_scan_register_allocator lsra_checker u_lsra_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

[dv/tb_top.sv]
// testbench for the linear scan register allocator: interval stimulus, allocation scoreboard
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lsra_pkg::*;

  localparam int unsigned NumRegs       = NumRegsDefault;
  localparam int unsigned ClkPeriod     = 8;
  localparam int unsigned IdleMax       = 18;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 2 * (NumRegs + 2) + 4;
  localparam int unsigned RandomItems   = 950;
  localparam int unsigned ResW          = $bits(lsra_result_t);

  // allocation scoreboard: mirrors the register file and queues the predicted results
  class alloc_scoreboard;
    int unsigned     usable;
    bit              held [NumRegs];
    logic [PosW-1:0] held_end [NumRegs];
    logic [VarW-1:0] held_var [NumRegs];
    lsra_result_t    expected_allocs [$];
    int unsigned     errors;

    function new();
      usable = CfgReset;
      errors = 0;
      foreach (held[k]) begin
        held[k]     = 1'b0;
        held_end[k] = '0;
        held_var[k] = '0;
      end
    endfunction

    function void set_register_count(logic [CfgW-1:0] value);
      usable = (value > NumRegs) ? NumRegs : value;
    endfunction

    // predicted allocation for one accepted interval
    function void note_interval(bit first, logic [VarW-1:0] vid,
                                logic [PosW-1:0] pos_begin, logic [PosW-1:0] pos_end);
      lsra_result_t res;
      int slot;
      int cand;
      res  = '0;
      slot = -1;
      cand = -1;
      res.result_variable = vid;
      if (first) begin
        foreach (held[k]) held[k] = 1'b0;
      end
      // free intervals that ended before the new begin
      foreach (held[k]) begin
        if (held[k] && held_end[k] < pos_begin) held[k] = 1'b0;
      end
      // lowest free usable register
      for (int k = 0; k < int'(usable); k++) begin
        if (!held[k]) begin
          slot = k;
          break;
        end
      end
      if (slot >= 0) begin
        held[slot]          = 1'b1;
        held_end[slot]      = pos_end;
        held_var[slot]      = vid;
        res.got_register    = 1'b1;
        res.register_number = slot[RegNumW-1:0];
      end else begin
        // greatest end, ties to the lowest register
        foreach (held[k]) begin
          if (held[k] && (cand < 0 || held_end[k] > held_end[cand])) cand = k;
        end
        res.spill_valid = 1'b1;
        if (cand >= 0 && held_end[cand] > pos_end) begin
          res.spilled_variable = held_var[cand];
          held_end[cand]       = pos_end;
          held_var[cand]       = vid;
          res.got_register     = 1'b1;
          res.register_number  = cand[RegNumW-1:0];
        end else begin
          res.spilled_variable = vid;
        end
      end
      expected_allocs = {expected_allocs, res};
    endfunction

    task report_mismatch(string field, logic [63:0] want, logic [63:0] got);
      $display("[alloc_sb] %0t %s: expected 0x%0h got 0x%0h", $time, field, want, got);
      errors++;
    endtask

    // compare one result transfer with the oldest prediction
    task check_result(logic [OutDataW-1:0] data);
      lsra_result_t seen;
      lsra_result_t want;
      seen = data[ResW-1:0];
      if (expected_allocs.size() == 0) begin
        report_mismatch("result with no interval pending", '0, data);
        return;
      end
      want = expected_allocs.pop_front();
      if (seen.result_variable !== want.result_variable)
        report_mismatch("result_variable", want.result_variable, seen.result_variable);
      if (seen.got_register !== want.got_register)
        report_mismatch("got_register", want.got_register, seen.got_register);
      if (seen.register_number !== want.register_number)
        report_mismatch("register_number", want.register_number, seen.register_number);
      if (seen.spill_valid !== want.spill_valid)
        report_mismatch("spill_valid", want.spill_valid, seen.spill_valid);
      if (seen.spilled_variable !== want.spilled_variable)
        report_mismatch("spilled_variable", want.spilled_variable, seen.spilled_variable);
      if (data[OutDataW-1:ResW] !== '0)
        report_mismatch("pad bits", '0, data[OutDataW-1:ResW]);
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgW-1:0]     cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  alloc_scoreboard sb;
  bit              send_idle    = 1'b1;
  bit              recv_idle    = 1'b1;
  int unsigned     quiet_cycles = 0;

  linear_scan_register_allocator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // one interval transfer, after a random gap when send_idle is set; valid stays high when there is no gap
  task automatic send_interval(bit first, logic [VarW-1:0] vid,
                               logic [PosW-1:0] pos_begin, logic [PosW-1:0] pos_end);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, IdleMax) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos_end, pos_begin, vid};
    s_axis_tuser  <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_interval(first, vid, pos_begin, pos_end);
  endtask

  // register count write, only once every pending result has drained
  task automatic set_register_count(logic [CfgW-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_allocs.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register_count(value);
  endtask

  // result side ready with a random stall before each result when recv_idle is set
  initial begin : result_sink
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = recv_idle ? $urandom_range(0, IdleMax) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned      sent;
    int unsigned      set_len;
    int unsigned      span;
    int unsigned      step_max;
    int unsigned      pos;
    int unsigned      pos_end;
    int               k;
    bit               opens_set;
    logic [CfgW-1:0]  count_val;
    sb   = new();
    sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every register, registers zero and one tied on the greatest end
    send_interval(1'b1, 16'h0000, 16'h0000, 16'hFFFF);
    for (k = 1; k < NumRegs; k++)
      send_interval(1'b0, 16'(k), 16'h0000, (k == 1) ? 16'hFFFF : 16'(16'h0100 + k));
    // tie on greatest end: the lower register is evicted
    send_interval(1'b0, 16'h1234, 16'h0000, 16'h1000);
    // equal end is not greater: the new interval goes to the stack
    send_interval(1'b0, 16'h4321, 16'h0000, 16'hFFFF);
    // expiry frees registers two and up; end below begin
    send_interval(1'b0, 16'hFFFF, 16'h0200, 16'h0000);
    // begin out of order
    send_interval(1'b0, 16'h5A5A, 16'h0050, 16'h0060);
    // count lowered to zero in mid-set: eviction still possible
    set_register_count(5'd0);
    send_interval(1'b0, 16'hC3C3, 16'h0300, 16'h0400);
    // zero count on an empty set: the new interval spills
    send_interval(1'b1, 16'h0F0F, 16'h0000, 16'h0005);
    // count above the register file is clamped
    set_register_count(5'd31);
    send_interval(1'b1, 16'hA5A5, 16'hFFFF, 16'hFFFF);
    // single register, evicted by a shorter interval
    set_register_count(5'd1);
    send_interval(1'b0, 16'h00FF, 16'hFFFF, 16'h0000);
    send_interval(1'b1, 16'hFF00, 16'h0000, 16'h0000);

    // random sets of sorted intervals with some noise
    while (sent < RandomItems) begin
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       count_val = 5'd0;
          1:       count_val = 5'd1;
          2:       count_val = 5'(NumRegs);
          3:       count_val = 5'($urandom_range(17, 31));
          default: count_val = 5'($urandom_range(1, NumRegs));
        endcase
        set_register_count(count_val);
      end
      case ($urandom_range(0, 3))
        0:       span = 8;
        1:       span = 64;
        2:       span = 1024;
        default: span = 65535;
      endcase
      set_len   = $urandom_range(1, 40);
      step_max  = ($urandom_range(0, 3) == 0) ? 64 : 4;
      pos       = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 255);
      opens_set = ($urandom_range(0, 9) != 0);
      for (k = 0; k < int'(set_len); k++) begin
        if ($urandom_range(0, 19) == 0) begin
          // noise: any field values
          send_interval($urandom_range(0, 9) == 0, 16'($urandom()), 16'($urandom()),
                        16'($urandom()));
        end else begin
          pos     = pos + $urandom_range(0, step_max);
          pos     = (pos > 65535) ? 65535 : pos;
          pos_end = pos + $urandom_range(0, span);
          pos_end = (pos_end > 65535) ? 65535 : pos_end;
          send_interval(k == 0 && opens_set, 16'($urandom()), 16'(pos), 16'(pos_end));
        end
        sent++;
      end
    end

    // drain, then keep watching for stray results
    s_axis_tvalid <= 1'b0;
    while (sb.expected_allocs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_allocs.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hdl/lsra_pkg.sv
hdl/lsra_out_reg.sv
hdl/linear_scan_register_allocator.sv
hdl/lsra_checker.sv
dv/tb_top.sv
